// File: rtl/core/dlt_pkg.sv
package dlt_pkg;

    localparam int LEASE_SLOTS_DEF = 8;
    localparam int IDX_W           = 6;   // covers up to 64 slots
    localparam int LIM_W           = 4;   // list limit, 0..MAX_RES
    localparam int MAX_RES         = 8;
    localparam logic [31:0] LEASE_LEN_RST = 32'd120000;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    localparam logic [1:0] IF_UNKNOWN = 2'd0;
    localparam logic [1:0] IF_BAD     = 2'd3;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_REFRESH = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_REMOVED = 3'd4;
    localparam logic [2:0] ST_ENTRY   = 3'd5;
    localparam logic [2:0] ST_EMPTY   = 3'd6;

    // item travelling down the row of cells
    typedef struct packed {
        logic             valid;
        logic [1:0]       op;
        logic [1:0]       iface;
        logic [31:0]      ip;
        logic [47:0]      mac;
        logic [31:0]      now;
        logic [LIM_W-1:0] limit;
        logic [6:0]       cnt;
        logic             match_f;
        logic [IDX_W-1:0] match_idx;
        logic             empty_f;
        logic [IDX_W-1:0] empty_idx;
    } tok_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [1:0]       iface;
        logic [31:0]      ip;
        logic [47:0]      mac;
        logic [31:0]      now;
    } wr_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  iface;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] remaining;
    } rep_t;

endpackage

// File: rtl/core/dlt_cell.sv
module dlt_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       lease_len,
    input  dlt_pkg::tok_t     tok_in,
    input  dlt_pkg::wr_t      wr,
    output dlt_pkg::tok_t     tok_out,
    output dlt_pkg::rep_t     rep
);
    import dlt_pkg::*;

    logic        active_reg, active_next;
    logic [1:0]  iface_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [31:0] seen_reg;
    tok_t        tok_reg, tok_next;

    logic [31:0] elapsed;
    logic        expired;
    logic        aged_act;
    logic        wr_hit;

    assign elapsed  = tok_in.now - seen_reg;
    assign expired  = elapsed >= lease_len;
    assign aged_act = active_reg && !expired;
    assign wr_hit   = wr.en && (wr.idx == IDX_W'(IDX));

    always_comb
    begin
        tok_next    = tok_in;
        active_next = active_reg;
        rep         = '0;
        if (tok_in.valid)
        begin
            case (tok_in.op)
                OP_RECORD:
                begin
                    active_next = aged_act;
                    if (aged_act && !tok_in.match_f && iface_reg == tok_in.iface
                        && (ip_reg == tok_in.ip || mac_reg == tok_in.mac))
                    begin
                        tok_next.match_f   = 1'b1;
                        tok_next.match_idx = IDX_W'(IDX);
                    end
                    if (!aged_act && !tok_in.empty_f)
                    begin
                        tok_next.empty_f   = 1'b1;
                        tok_next.empty_idx = IDX_W'(IDX);
                    end
                end
                OP_REMOVE:
                begin
                    if (active_reg && mac_reg == tok_in.mac
                        && (tok_in.ip == 32'd0 || ip_reg == tok_in.ip))
                    begin
                        active_next  = 1'b0;
                        tok_next.cnt = tok_in.cnt + 7'd1;
                    end
                end
                OP_LIST:
                begin
                    active_next = aged_act;
                    if (aged_act && tok_in.cnt < {3'b000, tok_in.limit})
                    begin
                        rep.valid     = 1'b1;
                        rep.iface     = iface_reg;
                        rep.ip        = ip_reg;
                        rep.mac       = mac_reg;
                        rep.remaining = lease_len - elapsed;
                        tok_next.cnt  = tok_in.cnt + 7'd1;
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
        if (wr_hit)
        begin
            active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            iface_reg <= wr.iface;
            ip_reg    <= wr.ip;
            mac_reg   <= wr.mac;
            seen_reg  <= wr.now;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: rtl/core/dhcp_lease_table_with_expiry_top.sv
// Lease table with aging, built as a row of slot cells.
// Command channel: an item (opcode, iface, ip_addr, mac_addr, now_ticks,
// max_count) is taken on a clock edge with start high and busy low.
// Results leave on status .. last, valid for one cycle while result_valid
// is high; the receiver cannot stall, so every result is simply presented
// once. last marks the final result of an item.
// Configuration: cfg_wr_en/cfg_wr_data write the lease length in ticks;
// write only while busy is low and no result is pending.
// Record, remove and list items walk a token through the cells, one cell
// per cycle; each cell ages, matches or reports its own slot as the token
// passes. List entries appear while the token walks, each held in a
// pending register until the next entry or the end of the walk.
// Ignored items (bad opcode, bad interface or zero address on record) and
// a list with max_count zero answer in the cycle after start is taken.
// The walk covers the whole row of cells and busy stays high meanwhile,
// so a new item is taken only after the last one has finished its walk.
// Reset clears every active mark and sets the lease length to 120000.
module dhcp_lease_table_with_expiry_top #(
    parameter int LEASE_SLOTS = dlt_pkg::LEASE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [1:0]  iface,
    input  logic [31:0] ip_addr,
    input  logic [47:0] mac_addr,
    input  logic [31:0] now_ticks,
    input  logic [6:0]  max_count,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [6:0]  removed_count,
    output logic [31:0] entry_ip,
    output logic [47:0] entry_mac,
    output logic [1:0]  entry_iface,
    output logic [31:0] remaining_ticks,
    output logic        last
);
    import dlt_pkg::*;

    logic [31:0] lease_reg;
    logic        busy_reg, busy_next;
    tok_t        launch_reg, launch_next;

    tok_t tok_w [0:LEASE_SLOTS];
    rep_t rep_w [0:LEASE_SLOTS-1];
    rep_t rep_any;
    wr_t  wr;

    // list entry held back one step so that last can be set on it
    rep_t pend_reg, pend_next;

    logic        rv_reg, rv_next;
    logic [2:0]  st_reg, st_next;
    logic [6:0]  rc_reg, rc_next;
    logic [31:0] eip_reg, eip_next;
    logic [47:0] emac_reg, emac_next;
    logic [1:0]  eif_reg, eif_next;
    logic [31:0] rem_reg, rem_next;
    logic        last_reg, last_next;

    logic             accept;
    logic [LIM_W-1:0] limit;
    tok_t             fin;

    assign accept = start && !busy_reg;
    assign limit  = (max_count > 7'(MAX_RES)) ? LIM_W'(MAX_RES) : max_count[LIM_W-1:0];
    assign fin    = tok_w[LEASE_SLOTS];

    assign tok_w[0] = launch_reg;

    genvar g;
    generate
        for (g = 0; g < LEASE_SLOTS; g++)
        begin : g_cell
            dlt_cell #(.IDX(g)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .lease_len (lease_reg),
                .tok_in    (tok_w[g]),
                .wr        (wr),
                .tok_out   (tok_w[g+1]),
                .rep       (rep_w[g])
            );
        end
    endgenerate

    // only the cell holding the token can report
    always_comb
    begin
        rep_any = '0;
        for (int i = 0; i < LEASE_SLOTS; i++)
        begin
            rep_any = rep_any | rep_w[i];
        end
    end

    always_comb
    begin
        wr       = '0;
        wr.iface = fin.iface;
        wr.ip    = fin.ip;
        wr.mac   = fin.mac;
        wr.now   = fin.now;
        wr.idx   = fin.match_f ? fin.match_idx : fin.empty_idx;
        wr.en    = fin.valid && fin.op == OP_RECORD && (fin.match_f || fin.empty_f);
    end

    always_comb
    begin
        busy_next   = busy_reg;
        launch_next = '0;
        pend_next   = pend_reg;
        rv_next     = 1'b0;
        st_next     = ST_IGNORED;
        rc_next     = 7'd0;
        eip_next    = 32'd0;
        emac_next   = 48'd0;
        eif_next    = 2'd0;
        rem_next    = 32'd0;
        last_next   = 1'b1;

        if (accept)
        begin
            launch_next.op    = opcode;
            launch_next.iface = iface;
            launch_next.ip    = ip_addr;
            launch_next.mac   = mac_addr;
            launch_next.now   = now_ticks;
            launch_next.limit = limit;
            pend_next         = '0;
            case (opcode)
                OP_RECORD:
                begin
                    if (iface == IF_UNKNOWN || iface == IF_BAD || ip_addr == 32'd0)
                    begin
                        rv_next = 1'b1;
                    end
                    else
                    begin
                        launch_next.valid = 1'b1;
                        busy_next         = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    launch_next.valid = 1'b1;
                    busy_next         = 1'b1;
                end
                OP_LIST:
                begin
                    if (limit == '0)
                    begin
                        rv_next = 1'b1;
                        st_next = ST_EMPTY;
                    end
                    else
                    begin
                        launch_next.valid = 1'b1;
                        busy_next         = 1'b1;
                    end
                end
                default:
                begin
                    rv_next = 1'b1;
                end
            endcase
        end

        if (rep_any.valid)
        begin
            pend_next = rep_any;
            if (pend_reg.valid)
            begin
                rv_next   = 1'b1;
                st_next   = ST_ENTRY;
                eip_next  = pend_reg.ip;
                emac_next = pend_reg.mac;
                eif_next  = pend_reg.iface;
                rem_next  = pend_reg.remaining;
                last_next = 1'b0;
            end
        end

        if (fin.valid)
        begin
            busy_next = 1'b0;
            rv_next   = 1'b1;
            case (fin.op)
                OP_RECORD:
                begin
                    st_next = fin.match_f ? ST_REFRESH : (fin.empty_f ? ST_NEW : ST_FULL);
                end
                OP_REMOVE:
                begin
                    st_next = ST_REMOVED;
                    rc_next = fin.cnt;
                end
                default:
                begin
                    if (pend_reg.valid)
                    begin
                        st_next   = ST_ENTRY;
                        eip_next  = pend_reg.ip;
                        emac_next = pend_reg.mac;
                        eif_next  = pend_reg.iface;
                        rem_next  = pend_reg.remaining;
                    end
                    else
                    begin
                        st_next = ST_EMPTY;
                    end
                    pend_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lease_reg  <= LEASE_LEN_RST;
            busy_reg   <= 1'b0;
            launch_reg <= '0;
            pend_reg   <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lease_reg <= cfg_wr_data;
            end
            busy_reg   <= busy_next;
            launch_reg <= launch_next;
            pend_reg   <= pend_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        rc_reg   <= rc_next;
        eip_reg  <= eip_next;
        emac_reg <= emac_next;
        eif_reg  <= eif_next;
        rem_reg  <= rem_next;
        last_reg <= last_next;
    end

    assign busy            = busy_reg;
    assign result_valid    = rv_reg;
    assign status          = st_reg;
    assign removed_count   = rc_reg;
    assign entry_ip        = eip_reg;
    assign entry_mac       = emac_reg;
    assign entry_iface     = eif_reg;
    assign remaining_ticks = rem_reg;
    assign last            = last_reg;

endmodule

// File: sim/dhcp_lease_table_with_expiry_top_tb.sv
`timescale 1ns / 1ps

module dhcp_lease_table_with_expiry_top_tb;
    import dlt_pkg::*;

    localparam int SLOTS = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  ifc;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] now;
        logic [6:0]  maxc;
    } lease_cmd_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [6:0]  rem_cnt;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [1:0]  ifc;
        logic [31:0] left;
        logic        fin;
    } lease_res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [1:0]  iface;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [31:0] now_ticks;
    logic [6:0]  max_count;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        result_valid;
    logic [2:0]  status;
    logic [6:0]  removed_count;
    logic [31:0] entry_ip;
    logic [47:0] entry_mac;
    logic [1:0]  entry_iface;
    logic [31:0] remaining_ticks;
    logic        last;

    dhcp_lease_table_with_expiry_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .iface(iface), .ip_addr(ip_addr), .mac_addr(mac_addr),
        .now_ticks(now_ticks), .max_count(max_count),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .result_valid(result_valid), .status(status), .removed_count(removed_count),
        .entry_ip(entry_ip), .entry_mac(entry_mac), .entry_iface(entry_iface),
        .remaining_ticks(remaining_ticks), .last(last)
    );

    // shadow copy of the lease table, updated as each item is accepted
    logic [31:0] lease_len;
    logic        sh_active [SLOTS];
    logic [1:0]  sh_iface  [SLOTS];
    logic [31:0] sh_ip     [SLOTS];
    logic [47:0] sh_mac    [SLOTS];
    logic [31:0] sh_seen   [SLOTS];

    lease_cmd_t pending_cmds[$];
    lease_res_t expected_results[$];
    int  mismatches;
    int  cycles;
    bit  phase_busy;   // stimulus phase still queued or in flight
    int  burst_left;
    int  gap_left;
    int  stall_phase;
    int  ip_pool_idx;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic lease_res_t one_result(logic [2:0] st, logic [6:0] n);
        lease_res_t r;
        r = '0;
        r.st = st;
        r.rem_cnt = n;
        r.fin = 1'b1;
        return r;
    endfunction

    task automatic age_slots(logic [31:0] now);
        for (int i = 0; i < SLOTS; i++)
            if (sh_active[i] && (now - sh_seen[i]) >= lease_len)
                sh_active[i] = 1'b0;
    endtask

    // work out the results of one accepted item and update the shadow table
    task automatic predict_lease_op(lease_cmd_t c);
        int hit;
        int free_slot;
        int slot;
        int n;
        int lim;
        logic [31:0] el;
        lease_res_t r;
        hit = -1;
        free_slot = -1;
        n = 0;
        case (c.op)
            OP_RECORD:
            begin
                if (c.ifc == IF_UNKNOWN || c.ifc == IF_BAD || c.ip == 0)
                begin
                    expected_results.push_back(one_result(ST_IGNORED, 7'd0));
                end
                else
                begin
                    age_slots(c.now);
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!sh_active[i])
                        begin
                            if (free_slot < 0)
                                free_slot = i;
                        end
                        else if (hit < 0 && sh_iface[i] == c.ifc &&
                                 (sh_ip[i] == c.ip || sh_mac[i] == c.mac))
                            hit = i;
                    end
                    // the first free slot is used only when no slot matches; the scan
                    // goes on past a match, and a match wins wherever it lies
                    slot = (hit >= 0) ? hit : free_slot;
                    if (slot < 0)
                        expected_results.push_back(one_result(ST_FULL, 7'd0));
                    else
                    begin
                        sh_active[slot] = 1'b1;
                        sh_iface[slot] = c.ifc;
                        sh_ip[slot] = c.ip;
                        sh_mac[slot] = c.mac;
                        sh_seen[slot] = c.now;
                        expected_results.push_back(
                            one_result(hit >= 0 ? ST_REFRESH : ST_NEW, 7'd0));
                    end
                end
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (sh_active[i] && sh_mac[i] == c.mac && (c.ip == 0 || sh_ip[i] == c.ip))
                    begin
                        sh_active[i] = 1'b0;
                        n++;
                    end
                expected_results.push_back(one_result(ST_REMOVED, n[6:0]));
            end
            OP_LIST:
            begin
                lim = (c.maxc < MAX_RES) ? c.maxc : MAX_RES;
                if (lim != 0)
                begin
                    age_slots(c.now);
                    for (int i = 0; i < SLOTS; i++)
                        if (sh_active[i] && n < lim)
                        begin
                            el = c.now - sh_seen[i];
                            r = '0;
                            r.st = ST_ENTRY;
                            r.ip = sh_ip[i];
                            r.mac = sh_mac[i];
                            r.ifc = sh_iface[i];
                            r.left = (el >= lease_len) ? 32'd0 : lease_len - el;
                            n++;
                            r.fin = (n == lim);
                            expected_results.push_back(r);
                        end
                end
                if (n == 0)
                    expected_results.push_back(one_result(ST_EMPTY, 7'd0));
                else
                    expected_results[$].fin = 1'b1;
            end
            default:
                expected_results.push_back(one_result(ST_IGNORED, 7'd0));
        endcase
    endtask

    // driver: bursts of items with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_lease_op({opcode, iface, ip_addr, mac_addr, now_ticks, max_count});
            if ((start && !busy) || !start)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    lease_cmd_t c;
                    c = pending_cmds.pop_front();
                    start     <= 1'b1;
                    opcode    <= c.op;
                    iface     <= c.ifc;
                    ip_addr   <= c.ip;
                    mac_addr  <= c.mac;
                    now_ticks <= c.now;
                    max_count <= c.maxc;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 6);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: the receiver cannot stall, so every strobe is checked
    always @(posedge clk)
    begin
        lease_res_t got;
        lease_res_t exp_r;
        if (rst_n)
        begin
            stall_phase <= stall_phase + 1;   // receiver pattern has no effect
            if (result_valid)
            begin
                got = {status, removed_count, entry_ip, entry_mac, entry_iface,
                       remaining_ticks, last};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch st %0d/%0d rm %0d/%0d ip %h/%h mac %h/%h",
                                      " if %0d/%0d rt %0d/%0d last %0d/%0d"},
                                     exp_r.st, got.st, exp_r.rem_cnt, got.rem_cnt,
                                     exp_r.ip, got.ip, exp_r.mac, got.mac,
                                     exp_r.ifc, got.ifc, exp_r.left, got.left,
                                     exp_r.fin, got.fin);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("dhcp_lease_table_with_expiry_top test failed");
            $finish;
        end
    end

    // small pools so records, refreshes and removes collide often
    function automatic logic [31:0] pick_ip();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return $urandom();
            default: return 32'h0A00_0000 + $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [47:0] pick_mac();
        case ($urandom_range(0, 9))
            0: return 48'hFFFF_FFFF_FFFF;
            1: return 48'({$urandom(), $urandom()});
            default: return 48'h0200_0000_0000 + 48'($urandom_range(0, 6));
        endcase
    endfunction

    function automatic lease_cmd_t rand_cmd(logic [31:0] t);
        lease_cmd_t c;
        int k;
        k = $urandom_range(0, 99);
        c.now = t;
        c.ip = pick_ip();
        c.mac = pick_mac();
        c.ifc = 2'($urandom_range(1, 2));
        c.maxc = 7'($urandom_range(1, 9));
        if (k < 50)
            c.op = OP_RECORD;
        else if (k < 65)
        begin
            c.op = OP_REMOVE;
            if ($urandom_range(0, 2) == 0)
                c.ip = '0;
        end
        else if (k < 90)
            c.op = OP_LIST;
        else
        begin
            // noise: bad opcode, bad interface, zero address, odd counts
            c.op = 2'($urandom_range(0, 3));
            c.ifc = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 1))
                c.ip = '0;
            c.maxc = 7'($urandom_range(0, 127));
        end
        return c;
    endfunction

    task automatic push_cmd(logic [1:0] op, logic [1:0] ifc, logic [31:0] ip,
                            logic [47:0] mac, logic [31:0] now, logic [6:0] maxc);
        pending_cmds.push_back({op, ifc, ip, mac, now, maxc});
    endtask

    // let queued items drain, then give the walk time to settle before a write
    task automatic drain_then_write(logic [31:0] len);
        while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge clk);
        repeat (SLOTS + 6) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        lease_len = len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] t;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = '0;
        iface = '0;
        ip_addr = '0;
        mac_addr = '0;
        now_ticks = '0;
        max_count = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        lease_len = LEASE_LEN_RST;
        for (int i = 0; i < SLOTS; i++)
        begin
            sh_active[i] = 1'b0;
            sh_iface[i] = '0;
            sh_ip[i] = '0;
            sh_mac[i] = '0;
            sh_seen[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default lease length, fill past full, refresh, remove, list
        push_cmd(OP_LIST, 2'd1, 0, 0, 0, 7'd8);                 // empty table
        push_cmd(OP_RECORD, IF_UNKNOWN, 32'h1, 48'h1, 0, 0);    // unknown iface
        push_cmd(OP_RECORD, IF_BAD, 32'h1, 48'h1, 0, 0);        // invalid iface
        push_cmd(OP_RECORD, 2'd1, 32'h0, 48'h1, 0, 0);          // zero address
        push_cmd(2'd3, 2'd1, 32'h1, 48'h1, 0, 0);               // unused opcode
        for (int i = 0; i < 9; i++)                              // ninth is dropped
            push_cmd(OP_RECORD, (i % 2) ? 2'd2 : 2'd1,
                     (i == 0) ? 32'hFFFF_FFFF : 32'hC0A8_0000 + i,
                     (i == 1) ? 48'hFFFF_FFFF_FFFF : 48'h1000 + i, 32'd100 + i, 0);
        push_cmd(OP_RECORD, 2'd1, 32'hFFFF_FFFF, 48'h9999, 32'd200, 0);  // refresh by ip
        push_cmd(OP_LIST, 2'd0, 0, 0, 32'd300, 7'd0);            // zero max_count
        push_cmd(OP_LIST, 2'd0, 0, 0, 32'd300, 7'd127);          // clipped at eight
        push_cmd(OP_LIST, 2'd0, 0, 0, 32'd300, 7'd3);
        push_cmd(OP_REMOVE, 2'd0, 32'h0, 48'hFFFF_FFFF_FFFF, 0, 0);   // any address
        push_cmd(OP_REMOVE, 2'd0, 32'hC0A8_0002, 48'h1002, 0, 0);
        push_cmd(OP_REMOVE, 2'd3, 32'h1234, 48'h5555, 0, 0);      // no match
        push_cmd(OP_LIST, 2'd3, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 7'd8);

        // phases with different lease lengths, including both extremes
        t = $urandom();
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: drain_then_write(32'd1);
                1: drain_then_write(32'd0);
                2: drain_then_write(32'hFFFF_FFFF);
                3: drain_then_write(32'd50);
                default: drain_then_write(LEASE_LEN_RST);
            endcase
            for (int i = 0; i < 28; i++)
            begin
                // small steps keep leases alive; occasional jumps make them expire
                t = t + (($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 40));
                pending_cmds.push_back(rand_cmd(t));
            end
        end

        while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge clk);
        repeat (SLOTS + 6) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("dhcp_lease_table_with_expiry_top test passed");
        else
            $display("dhcp_lease_table_with_expiry_top test failed");
        $finish;
    end
endmodule
